/* rtl/mep_pkg.sv */
// Shared types, saturation helper and palette functions for the escape-time pixel colorer.
package mep_pkg;

    localparam int CNT_W = 8;  // holds any iteration limit up to 255

    typedef struct packed {
        logic signed [31:0] cr;
        logic signed [31:0] ci;
        logic signed [31:0] zr;
        logic signed [31:0] zi;
        logic               done;
        logic [CNT_W-1:0]   cnt;
    } mep_item_t;

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [31:0] r;
        if (v > 68'sh0_0000_0000_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -68'sh0_0000_0000_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    // restoring division, elaboration use only
    function automatic int udiv(input int a, input int b);
        int q;
        int rem;
        q = 0;
        rem = 0;
        for (int i = 30; i >= 0; i--) begin
            rem = (rem << 1) | ((a >> i) & 1);
            if (rem >= b) begin
                rem = rem - b;
                q = q | (1 << i);
            end
        end
        return q;
    endfunction

    function automatic int cdiv(input int a, input int b);
        return udiv(a + b - 1, b);
    endfunction

    function automatic int sqrt_floor(input int k, input int q, input int m);
        int x;
        x = 0;
        for (int i = 1; i <= k; i++)
            if (i * i * m <= k * k * q) x = i;
        return x;
    endfunction

    function automatic int sqrt_ceil(input int k, input int q, input int m);
        int x;
        x = k;
        for (int i = k; i >= 0; i--)
            if (i * i * m >= k * k * q) x = i;
        return x;
    endfunction

    // {blue, green, red} for n = limit minus count, m = limit
    function automatic logic [23:0] pal_rgb(input int n, input int m);
        int r;
        int g;
        int b;
        int q;
        if (5 * n < m) begin
            r = udiv(1275 * n, m);
            g = r;
            b = r;
        end else if (5 * n < 2 * m) begin
            q = 5 * n - m;
            r = 255;
            g = 255 - cdiv(94 * q, m);
            b = 255 - cdiv(255 * q, m);
        end else if (5 * n < 3 * m) begin
            q = 5 * n - 2 * m;
            r = 255 - sqrt_ceil(255, q, m);
            g = 161 - sqrt_ceil(40, q, m);
            b = sqrt_floor(241, q, m);
        end else begin
            q = 5 * n - 3 * m;
            r = 0;
            g = 121 - cdiv(121 * q, 2 * m);
            b = 241 - cdiv(241 * q, 2 * m);
        end
        return {b[7:0], g[7:0], r[7:0]};
    endfunction

endpackage

/* rtl/mep_cmap.sv */
// Pixel to complex-plane mapping: c = step * (coordinate - origin), saturated.
module mep_cmap
    import mep_pkg::*;
#(
    parameter int MAX_ITER = 30
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  logic [9:0]  column,
    input  logic [9:0]  row,
    input  logic [24:0] step_size,
    input  logic [9:0]  origin_column,
    input  logic [9:0]  origin_row,
    output logic        out_valid,
    output mep_item_t   out_item
);

    logic               v1_reg, v2_reg, v3_reg;
    logic signed [10:0] dc_reg, dr_reg;
    logic signed [36:0] pc_reg, pr_reg;
    mep_item_t          item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dc_reg <= $signed({1'b0, column}) - $signed({1'b0, origin_column});
            dr_reg <= $signed({1'b0, row}) - $signed({1'b0, origin_row});
            pc_reg <= $signed({1'b0, step_size}) * dc_reg;
            pr_reg <= $signed({1'b0, step_size}) * dr_reg;
            item_reg.cr   <= sat32(68'(pc_reg));
            item_reg.ci   <= sat32(68'(pr_reg));
            item_reg.zr   <= '0;
            item_reg.zi   <= '0;
            item_reg.done <= 1'b0;
            item_reg.cnt  <= CNT_W'(MAX_ITER);
        end
    end

    assign out_valid = v3_reg;
    assign out_item  = item_reg;

endmodule

/* rtl/mep_iter.sv */
// One unrolled iteration z = z^2 + c + offset with escape test, four stages.
module mep_iter
    import mep_pkg::*;
#(
    parameter int K         = 0,
    parameter int FRAC_BITS = 24
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  mep_item_t          in_item,
    input  logic signed [31:0] offset_real,
    input  logic signed [31:0] offset_imag,
    input  logic [30:0]        radius_squared,
    output logic               out_valid,
    output mep_item_t          out_item
);

    logic               va_reg, vb_reg, vc_reg, vd_reg;
    mep_item_t          a_reg, b_reg, c_reg, d_reg;
    mep_item_t          b_next, d_next;
    logic signed [63:0] prr_reg, pii_reg, pri_reg;
    logic signed [32:0] dr_reg, di_reg;
    logic [67:0]        sr_reg, si_reg;
    logic signed [31:0] nr_next, ni_next;
    logic signed [65:0] qr, qi;
    logic [67:0]        dist_sum;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end else if (en) begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    always_comb begin
        nr_next = sat32(68'(prr_reg >>> FRAC_BITS) - 68'(pii_reg >>> FRAC_BITS)
                        + 68'(a_reg.cr) + 68'(offset_real));
        ni_next = sat32(68'(pri_reg >>> (FRAC_BITS - 1)) + 68'(a_reg.ci)
                        + 68'(offset_imag));
        qr       = dr_reg * dr_reg;
        qi       = di_reg * di_reg;
        dist_sum = sr_reg + si_reg;
        // finished items pass through untouched
        b_next = a_reg;
        if (!a_reg.done) begin
            b_next.zr = nr_next;
            b_next.zi = ni_next;
        end
        d_next = c_reg;
        if (!c_reg.done && dist_sum > 68'(radius_squared)) begin
            d_next.done = 1'b1;
            d_next.cnt  = CNT_W'(K);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // stage A: products
            a_reg   <= in_item;
            prr_reg <= in_item.zr * in_item.zr;
            pii_reg <= in_item.zi * in_item.zi;
            pri_reg <= in_item.zr * in_item.zi;
            // stage B: new z, distance from c
            b_reg  <= b_next;
            dr_reg <= 33'(nr_next) - 33'(a_reg.cr);
            di_reg <= 33'(ni_next) - 33'(a_reg.ci);
            // stage C: squares
            c_reg  <= b_reg;
            sr_reg <= 68'(qr[65:0] >> FRAC_BITS);
            si_reg <= 68'(qi[65:0] >> FRAC_BITS);
            // stage D: escape test
            d_reg <= d_next;
        end
    end

    assign out_valid = vd_reg;
    assign out_item  = d_reg;

endmodule

/* rtl/mep_color.sv */
// Palette lookup and output register.
module mep_color
    import mep_pkg::*;
#(
    parameter int MAX_ITER = 30
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  mep_item_t   in_item,
    output logic        out_valid,
    output logic [39:0] out_word
);

    localparam int IDX_W = $clog2(MAX_ITER + 1);

    logic [23:0] pal [MAX_ITER+1];
    logic        v_reg;
    logic [39:0] word_reg;

    for (genvar g = 0; g <= MAX_ITER; g++) begin : g_pal
        assign pal[g] = pal_rgb(MAX_ITER - g, MAX_ITER);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) v_reg <= 1'b0;
        else if (en)  v_reg <= in_valid;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            word_reg <= {2'b00, 8'hFF, pal[in_item.cnt[IDX_W-1:0]],
                         in_item.done, in_item.cnt[4:0]};
        end
    end

    assign out_valid = v_reg;
    assign out_word  = word_reg;

endmodule

/* rtl/mandelbrot_escape_pixel_color.sv */
// Escape-time pixel colorer, top level.
// One pixel word per clock while the output is not stalled: column/row map to c,
// then MAX_ITER unrolled iterations of 4 register stages each (multiply,
// add/saturate, square, compare), then a palette lookup register. Throughput
// is one word per cycle unless m_tready stalls, set by the fully unrolled
// iteration chain. The whole pipe advances together and holds while the
// output word waits with m_tready low.
// Configuration writes are always accepted and must only happen with the
// pipe empty; the iteration count is the zero-based escaping iteration or
// MAX_ITER if the point never escapes.
module mandelbrot_escape_pixel_color
    import mep_pkg::*;
#(
    parameter int MAX_ITER  = 30,
    parameter int FRAC_BITS = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // column[9:0], row[19:10], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // iterations, escaped, red, green, blue, alpha
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam logic [2:0] REG_OFF_R  = 3'd0;
    localparam logic [2:0] REG_OFF_I  = 3'd1;
    localparam logic [2:0] REG_STEP   = 3'd2;
    localparam logic [2:0] REG_ORG_C  = 3'd3;
    localparam logic [2:0] REG_ORG_R  = 3'd4;
    localparam logic [2:0] REG_RADIUS = 3'd5;

    logic signed [31:0] off_r_reg, off_i_reg;
    logic [24:0]        step_reg;
    logic [9:0]         org_c_reg, org_r_reg;
    logic [30:0]        radius_reg;
    logic               en;

    logic      v [MAX_ITER+1];
    mep_item_t it [MAX_ITER+1];

    assign cfg_ready = 1'b1;
    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_r_reg  <= '0;
            off_i_reg  <= '0;
            step_reg   <= 25'd50332;
            org_c_reg  <= 10'd666;
            org_r_reg  <= 10'd500;
            radius_reg <= 31'd419430400;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_OFF_R:  off_r_reg  <= cfg_data;
                REG_OFF_I:  off_i_reg  <= cfg_data;
                REG_STEP:   step_reg   <= cfg_data[24:0];
                REG_ORG_C:  org_c_reg  <= cfg_data[9:0];
                REG_ORG_R:  org_r_reg  <= cfg_data[9:0];
                REG_RADIUS: radius_reg <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    mep_cmap #(.MAX_ITER(MAX_ITER)) u_cmap (
        .aclk, .aresetn, .en,
        .in_valid      (s_tvalid),
        .column        (s_tdata[9:0]),
        .row           (s_tdata[19:10]),
        .step_size     (step_reg),
        .origin_column (org_c_reg),
        .origin_row    (org_r_reg),
        .out_valid     (v[0]),
        .out_item      (it[0])
    );

    // one instance per iteration
    for (genvar k = 0; k < MAX_ITER; k++) begin : g_iter
        mep_iter #(.K(k), .FRAC_BITS(FRAC_BITS)) u_iter (
            .aclk, .aresetn, .en,
            .in_valid       (v[k]),
            .in_item        (it[k]),
            .offset_real    (off_r_reg),
            .offset_imag    (off_i_reg),
            .radius_squared (radius_reg),
            .out_valid      (v[k+1]),
            .out_item       (it[k+1])
        );
    end

    mep_color #(.MAX_ITER(MAX_ITER)) u_color (
        .aclk, .aresetn, .en,
        .in_valid  (v[MAX_ITER]),
        .in_item   (it[MAX_ITER]),
        .out_valid (m_tvalid),
        .out_word  (m_tdata)
    );

`ifndef ASSERT_OFF
    a_no_esc_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[5] |-> m_tdata[4:0] == 5'(MAX_ITER))
        else $error("non-escaped word without full count");
    a_alpha: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[37:30] == 8'hFF)
        else $error("alpha not opaque");
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");
`endif

endmodule

/* tb/mandelbrot_escape_pixel_color_checker.sv */
// Checker for the escape-time pixel colorer: predicts each pixel's word and compares.
`timescale 1ns / 1ps
module mandelbrot_escape_pixel_color_checker #(
    parameter int MAX_ITER  = 30,
    parameter int FRAC_BITS = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          pending
);

    localparam logic [2:0] REG_OFF_RE = 3'd0;
    localparam logic [2:0] REG_OFF_IM = 3'd1;
    localparam logic [2:0] REG_STEP   = 3'd2;
    localparam logic [2:0] REG_ORG_C  = 3'd3;
    localparam logic [2:0] REG_ORG_R  = 3'd4;
    localparam logic [2:0] REG_RADIUS = 3'd5;

    // predictor copy of the configuration
    logic [31:0] off_re, off_im;
    logic [24:0] step_sz;
    logic [9:0]  org_c, org_r;
    logic [30:0] radius_sq;

    logic [39:0] pixel_q[$];

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint ceil_div(input longint a, input longint b);
        return (a + b - 1) / b;
    endfunction

    function automatic longint root_lo(input longint k, input longint q, input longint m);
        longint x;
        x = 0;
        while (x < k && (x + 1) * (x + 1) * m <= k * k * q) x++;
        return x;
    endfunction

    function automatic longint root_hi(input longint k, input longint q, input longint m);
        longint x;
        x = 0;
        while (x < k && x * x * m < k * k * q) x++;
        return x;
    endfunction

    // squared magnitude floored to fraction bits; d spans 33 bits so 66-bit square
    function automatic logic [127:0] dist_sq(input longint d);
        logic [127:0] mag;
        mag = (d < 0) ? -d : d;
        return (mag * mag) >> FRAC_BITS;
    endfunction

    function automatic logic [39:0] color_pixel(input logic [9:0] col, input logic [9:0] row);
        longint cr, ci, orr, oii, zr, zi, rr, ii, ri, k, n, m, q, r, g, b;
        logic [127:0] dsum;
        logic esc;
        cr  = clamp32(longint'(step_sz) * (longint'(col) - longint'(org_c)));
        ci  = clamp32(longint'(step_sz) * (longint'(row) - longint'(org_r)));
        orr = longint'($signed(off_re));
        oii = longint'($signed(off_im));
        zr = 0;
        zi = 0;
        esc = 1'b0;
        for (k = 0; k < MAX_ITER; k++) begin
            // arithmetic shift floors toward minus infinity
            rr = (zr * zr) >>> FRAC_BITS;
            ii = (zi * zi) >>> FRAC_BITS;
            ri = (zr * zi) >>> (FRAC_BITS - 1);
            zr = clamp32(rr - ii + cr + orr);
            zi = clamp32(ri + ci + oii);
            dsum = dist_sq(zr - cr) + dist_sq(zi - ci);
            if (dsum > {97'd0, radius_sq}) begin
                esc = 1'b1;
                break;
            end
        end
        m = MAX_ITER;
        n = m - k;
        if (5 * n < m) begin
            r = (1275 * n) / m; g = r; b = r;
        end else if (5 * n < 2 * m) begin
            q = 5 * n - m;
            r = 255; g = 255 - ceil_div(94 * q, m); b = 255 - ceil_div(255 * q, m);
        end else if (5 * n < 3 * m) begin
            q = 5 * n - 2 * m;
            r = 255 - root_hi(255, q, m); g = 161 - root_hi(40, q, m); b = root_lo(241, q, m);
        end else begin
            q = 5 * n - 3 * m;
            r = 0; g = 121 - ceil_div(121 * q, 2 * m); b = 241 - ceil_div(241 * q, 2 * m);
        end
        // alpha, blue, green, red, escaped, iterations from the top down; pad bits zero
        return {2'b00, 8'hFF, b[7:0], g[7:0], r[7:0], esc, k[4:0]};
    endfunction

    logic [39:0] want;
    assign pending = pixel_q.size();

    always @(posedge aclk) begin
        if (!aresetn) begin
            off_re    <= '0;
            off_im    <= '0;
            step_sz   <= 25'd50332;
            org_c     <= 10'd666;
            org_r     <= 10'd500;
            radius_sq <= 31'd419430400;
            fail_count <= 0;
            pixel_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_OFF_RE: off_re    <= cfg_data;
                    REG_OFF_IM: off_im    <= cfg_data;
                    REG_STEP:   step_sz   <= cfg_data[24:0];
                    REG_ORG_C:  org_c     <= cfg_data[9:0];
                    REG_ORG_R:  org_r     <= cfg_data[9:0];
                    REG_RADIUS: radius_sq <= cfg_data[30:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                pixel_q.push_back(color_pixel(s_tdata[9:0], s_tdata[19:10]));
            if (m_tvalid && m_tready) begin
                if (pixel_q.size() == 0) begin
                    $display("%0t: unexpected word %h", $time, m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    want = pixel_q.pop_front();
                    if (m_tdata[4:0] !== want[4:0] || m_tdata[5] !== want[5]
                        || m_tdata[13:6] !== want[13:6] || m_tdata[21:14] !== want[21:14]
                        || m_tdata[29:22] !== want[29:22] || m_tdata[37:30] !== want[37:30]
                        || m_tdata[39:38] !== want[39:38]) begin
                        $display("%0t: pixel mismatch expected %h actual %h",
                                 $time, want, m_tdata);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

/* tb/mandelbrot_escape_pixel_color_test.sv */
// Testbench top for the escape-time pixel colorer: stimulus, config phases, verdict.
`timescale 1ns / 1ps
module mandelbrot_escape_pixel_color_test;

    localparam int MAX_ITER = 30;
    localparam int LATENCY  = 4 * MAX_ITER + 4;
    localparam longint CYCLE_LIMIT = 400000;

    localparam logic [2:0] REG_OFF_RE = 3'd0;
    localparam logic [2:0] REG_OFF_IM = 3'd1;
    localparam logic [2:0] REG_STEP   = 3'd2;
    localparam logic [2:0] REG_ORG_C  = 3'd3;
    localparam logic [2:0] REG_ORG_R  = 3'd4;
    localparam logic [2:0] REG_RADIUS = 3'd5;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;       // column[9:0], row[19:10], zero pad
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;            // iterations, escaped, red, green, blue, alpha
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    int fail_count;
    int pending;
    int send_idle_pct = 0;  // percent of cycles the sender holds off
    int recv_idle_pct = 0;  // percent of cycles the receiver stalls
    bit hold_recv = 1'b0;   // long receiver stall request
    longint cycles = 0;

    always #5 aclk = ~aclk;

    mandelbrot_escape_pixel_color u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    mandelbrot_escape_pixel_color_checker u_chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("mandelbrot_escape_pixel_color_test NOT OK");
            $finish;
        end
    end

    // receiver: random stalls, or held low during a long stretch
    always @(negedge aclk) begin
        if (!aresetn || hold_recv)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // one pixel word; idles at random before offering; valid stays up afterwards
    // so words can go back to back, drain() drops it
    task automatic send_pixel(input logic [9:0] col, input logic [9:0] row);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, row, col};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (LATENCY + 8) @(negedge aclk);
    endtask

    // some pixels near the origin so counts spread; the rest at any coordinate
    task automatic random_pixels(input int count);
        logic [9:0] c, r;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(3) == 0) begin
                c = 10'($urandom);
                r = 10'($urandom);
            end else begin
                c = 10'($urandom_range(1023, 0));
                r = 10'($urandom_range(1023, 0));
                if ($urandom_range(1)) begin
                    c = 10'(int'($urandom_range(100)) + 566);
                    r = 10'(int'($urandom_range(200)) + 400);
                end
            end
            send_pixel(c, r);
        end
    endtask

    initial begin
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: corners, origin, and points inside/outside the set at defaults
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd0, 10'd1023);
        send_pixel(10'd1023, 10'd0);
        send_pixel(10'd666, 10'd500);   // c = 0, never escapes
        send_pixel(10'd500, 10'd500);   // deep inside main cardioid
        send_pixel(10'd700, 10'd500);
        send_pixel(10'd590, 10'd710);
        send_pixel(10'd640, 10'd720);   // near the boundary
        send_pixel(10'd800, 10'd600);
        send_pixel(10'h2AA, 10'h155);
        send_pixel(10'h155, 10'h2AA);
        drain();

        // extremes: huge step saturates c, zero radius escapes at once
        write_reg(REG_STEP, 32'd16777216);
        write_reg(REG_RADIUS, 32'd0);
        write_reg(REG_OFF_RE, 32'h7FFF_FFFF);
        write_reg(REG_OFF_IM, 32'h8000_0000);
        write_reg(REG_ORG_C, 32'd0);
        write_reg(REG_ORG_R, 32'd1023);
        send_pixel(10'd0, 10'd1023);
        send_pixel(10'd1023, 10'd0);
        send_pixel(10'd512, 10'd512);
        drain();
        write_reg(REG_RADIUS, 32'h7FFF_FFFF);
        write_reg(REG_OFF_RE, 32'd0);
        write_reg(REG_OFF_IM, 32'd0);
        write_reg(REG_STEP, 32'd0);      // c = 0 everywhere
        send_pixel(10'd3, 10'd1000);
        send_pixel(10'd1023, 10'd1023);
        drain();

        // back to a view with a spread of counts; phase 1
        write_reg(REG_STEP, 32'd50332);
        write_reg(REG_ORG_C, 32'd666);
        write_reg(REG_ORG_R, 32'd500);
        write_reg(REG_RADIUS, 32'd67108864);  // 4.0
        send_idle_pct = 21;
        recv_idle_pct = 77;
        random_pixels(300);

        // long receiver hold-off while the sender keeps offering
        fork
            begin
                @(negedge aclk);
                hold_recv = 1'b1;
                repeat (400) @(negedge aclk);
                hold_recv = 1'b0;
            end
            random_pixels(200);
        join
        // sender pauses until every pixel has come back
        drain();

        // phase 2 with a pan offset and a finer step
        write_reg(REG_OFF_RE, 32'hFF80_0000);  // -0.5
        write_reg(REG_OFF_IM, 32'h0040_0000);
        write_reg(REG_STEP, 32'd16777);
        write_reg(REG_RADIUS, 32'd419430400);
        send_idle_pct = 77;
        recv_idle_pct = 21;
        random_pixels(220);
        drain();

        // phase 3: no idling, random settings
        write_reg(REG_OFF_RE, $urandom_range(32'h0100_0000) - 32'h0080_0000);
        write_reg(REG_OFF_IM, $urandom_range(32'h0100_0000) - 32'h0080_0000);
        write_reg(REG_STEP, $urandom_range(100000));
        write_reg(REG_ORG_C, $urandom_range(1023));
        write_reg(REG_ORG_R, $urandom_range(1023));
        write_reg(REG_RADIUS, $urandom);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_pixels(220);
        drain();

        if (fail_count == 0)
            $display("mandelbrot_escape_pixel_color_test OK");
        else
            $display("mandelbrot_escape_pixel_color_test NOT OK");
        $finish;
    end

endmodule

/* files.f */
rtl/mep_pkg.sv
rtl/mep_cmap.sv
rtl/mep_iter.sv
rtl/mep_color.sv
rtl/mandelbrot_escape_pixel_color.sv
tb/mandelbrot_escape_pixel_color_checker.sv
tb/mandelbrot_escape_pixel_color_test.sv
